// ===== rtl/lble_pkg.sv =====
// Shared types and constants of the leaky bucket event limiter.
// Used by lble_divider and leaky_bucket_event_limiter; depends on nothing.
`default_nettype none

package lble_pkg;

    // Timestamp width default; the top level hands it down.
    localparam int TIME_BITS_DEFAULT = 48;

    // interval_seconds * 1000 stays below 2^26.
    localparam int PERIOD_BITS = 26;

    // The count reaches at most event_limit + 1 before it is checked.
    localparam int COUNT_BITS = 17;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int OUT_TDATA_BITS = 8;

    localparam logic [9:0] MS_PER_SECOND = 10'd1000;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_EVENT_LIMIT      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERVAL_SECONDS = 2'd1;

    typedef enum logic {
        DIV_PERIOD,
        DIV_DEBIT
    } div_mode_t;

    typedef struct packed {
        logic      start;
        div_mode_t mode;
    } div_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/lble_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, shared by both divisions.
// Depends on lble_pkg.
`default_nettype none

module lble_divider #(
    parameter int TIME_BITS = lble_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire lble_pkg::div_ctrl_t              ctrl,
    input  wire logic [TIME_BITS-1:0]             dividend,
    input  wire logic [lble_pkg::PERIOD_BITS-1:0] divisor,
    output logic                                  done,
    output logic [TIME_BITS-1:0]                  quotient,
    output logic [lble_pkg::PERIOD_BITS-1:0]      remainder
);
    import lble_pkg::*;

    localparam int CNT_BITS = $clog2(TIME_BITS + 1);

    logic [CNT_BITS-1:0]    cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [PERIOD_BITS-1:0] rem_reg;
    logic [PERIOD_BITS-1:0] div_reg;
    logic [TIME_BITS-1:0]   quo_reg;

    logic [PERIOD_BITS:0]   trial;
    logic [PERIOD_BITS:0]   diff;
    logic                   fits;
    logic [TIME_BITS-1:0]   quo_load;

    assign trial = {rem_reg, quo_reg[TIME_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    // Period division: only the low PERIOD_BITS of the dividend matter, so
    // move them to the top and run PERIOD_BITS steps.
    assign quo_load = (ctrl.mode == DIV_PERIOD)
                    ? {dividend[PERIOD_BITS-1:0], {(TIME_BITS - PERIOD_BITS){1'b0}}}
                    : dividend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (ctrl.mode == DIV_PERIOD) ? CNT_BITS'(PERIOD_BITS)
                                                      : CNT_BITS'(TIME_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rem_reg <= '0;
            div_reg <= divisor;
            quo_reg <= quo_load;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
            quo_reg <= {quo_reg[TIME_BITS-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/leaky_bucket_event_limiter.sv =====
// Leaky bucket event limiter: one flag per timestamped event.
// Each event runs the period division and then the drain division on the shared serial
// divider (ST_PERIOD, ST_DEBIT), then raises m_tvalid in ST_DONE once the output
// is free; s_tready stays low until then, so the next event waits for this one.
// Limit zero: no divisions, straight from ST_IDLE to ST_DONE.
// Reset (aresetn low, synchronous) clears state, output, config, count and reference.
`default_nettype none

module leaky_bucket_event_limiter #(
    parameter int TIME_BITS = lble_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // s_tdata: now_ms [TIME_BITS-1:0], zero padding above
    input  wire logic [((TIME_BITS + 7) / 8) * 8-1:0] s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // m_tdata: limit_reached [0], zero padding above
    output logic [lble_pkg::OUT_TDATA_BITS-1:0]      m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lble_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [lble_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import lble_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_DEBIT,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic                   m_tvalid_reg;
    logic                   flag_reg;
    logic [15:0]            limit_reg;
    logic [15:0]            interval_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [TIME_BITS-1:0]   ref_reg;
    logic [TIME_BITS-1:0]   now_reg;

    logic                   accept_in;
    logic                   out_ok;
    logic                   limit_on;
    logic [TIME_BITS-1:0]   elapsed;
    logic [PERIOD_BITS-1:0] period_next;
    logic [PERIOD_BITS-1:0] interval_ms;

    div_ctrl_t              div_ctrl;
    logic [TIME_BITS-1:0]   div_dividend;
    logic [PERIOD_BITS-1:0] div_divisor;
    logic                   div_done;
    logic [TIME_BITS-1:0]   div_quo;
    logic [PERIOD_BITS-1:0] div_rem;

    logic [COUNT_BITS-1:0]  count_next;
    logic [TIME_BITS-1:0]   ref_next;
    logic                   flag_next;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept_in = s_tvalid && s_tready;
    assign out_ok    = !m_tvalid_reg || m_tready;
    assign limit_on  = (limit_reg != '0);

    assign interval_ms = PERIOD_BITS'(interval_reg) * PERIOD_BITS'(MS_PER_SECOND);
    assign elapsed     = (now_reg >= ref_reg) ? (now_reg - ref_reg) : '0;
    // Raise a zero period to one millisecond.
    assign period_next = (div_quo[PERIOD_BITS-1:0] == '0) ? PERIOD_BITS'(1)
                                                        : div_quo[PERIOD_BITS-1:0];

    always_comb begin
        div_ctrl.start = (accept_in && limit_on) || (state_reg == ST_PERIOD && div_done);
        div_ctrl.mode  = (state_reg == ST_IDLE) ? DIV_PERIOD : DIV_DEBIT;
        div_dividend   = (state_reg == ST_IDLE) ? TIME_BITS'(interval_ms) : elapsed;
        div_divisor    = (state_reg == ST_IDLE) ? PERIOD_BITS'(limit_reg) : period_next;
    end

    lble_divider #(
        .TIME_BITS (TIME_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Drain, refill and overflow check. The drained reference time is
    // ref + debits * period, which equals now - remainder.
    always_comb begin
        count_next = count_reg;
        ref_next   = ref_reg;
        flag_next  = 1'b0;
        if (count_next != '0 && div_quo != '0) begin
            if (div_quo < TIME_BITS'(count_next)) begin
                count_next = count_next - div_quo[COUNT_BITS-1:0];
                ref_next   = now_reg - TIME_BITS'(div_rem);
            end else begin
                count_next = '0;
            end
        end
        if (count_next == '0) begin
            ref_next = now_reg;
        end
        count_next = count_next + COUNT_BITS'(1);
        if (count_next > COUNT_BITS'(limit_reg)) begin
            count_next = '0;
            ref_next   = now_reg;
            flag_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            now_reg <= s_tdata[TIME_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            flag_reg     <= 1'b0;
            limit_reg    <= '0;
            interval_reg <= '0;
            count_reg    <= '0;
            ref_reg      <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept_in) begin
                        state_reg <= limit_on ? ST_PERIOD : ST_DONE;
                    end
                end
                ST_PERIOD: begin
                    if (div_done) begin
                        state_reg <= ST_DEBIT;
                    end
                end
                ST_DEBIT: begin
                    if (div_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hold until the previous result is taken.
                    if (out_ok) begin
                        m_tvalid_reg <= 1'b1;
                        flag_reg     <= limit_on && flag_next;
                        if (limit_on) begin
                            count_reg <= count_next;
                            ref_reg   <= ref_next;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_EVENT_LIMIT: begin
                        limit_reg <= cfg_data;
                        count_reg <= '0;
                    end
                    CFG_INTERVAL_SECONDS: begin
                        interval_reg <= cfg_data;
                        count_reg    <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_BITS - 1){1'b0}}, flag_reg};

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && limit_on) |-> (count_reg <= COUNT_BITS'(limit_reg)))
        else $error("event count above limit while idle");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_in |=> !s_tready)
        else $error("input ready right after a transfer");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final step");

    a_divider_only_when_limited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctrl.start |-> limit_on)
        else $error("divider started with a zero limit");
`endif

endmodule

`default_nettype wire
